[rtl/dehp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehp_pkg
// Types, codes and lookup functions for the DICOM element header parser.
// ----------------------------------------------------------------------------
package dehp_pkg;

  // Default preamble length in bytes
  localparam int unsigned PREAMBLE_BYTES_DEF = 128;

  // Byte class codes as reported on the result stream
  localparam logic [3:0] CLS_PREAMBLE = 4'd0;
  localparam logic [3:0] CLS_MAGIC    = 4'd1;
  localparam logic [3:0] CLS_GROUP    = 4'd2;
  localparam logic [3:0] CLS_ELEMENT  = 4'd3;
  localparam logic [3:0] CLS_VR       = 4'd4;
  localparam logic [3:0] CLS_RESERVED = 4'd5;
  localparam logic [3:0] CLS_LENGTH   = 4'd6;
  localparam logic [3:0] CLS_VALUE    = 4'd7;
  localparam logic [3:0] CLS_IGNORED  = 4'd8;

  // Pixel data tag
  localparam logic [15:0] PIXEL_GROUP   = 16'h7FE0;
  localparam logic [15:0] PIXEL_ELEMENT = 16'h0010;

  // Result word layout
  localparam int unsigned OUT_DATA_W = 88;

  // Parser phase, one-hot
  typedef enum logic [8:0] {
    PH_PREAMBLE = 9'b0_0000_0001,
    PH_MAGIC    = 9'b0_0000_0010,
    PH_GROUP    = 9'b0_0000_0100,
    PH_ELEMENT  = 9'b0_0000_1000,
    PH_VR       = 9'b0_0001_0000,
    PH_RESERVED = 9'b0_0010_0000,
    PH_LENGTH   = 9'b0_0100_0000,
    PH_VALUE    = 9'b0_1000_0000,
    PH_IGNORED  = 9'b1_0000_0000
  } phase_t;

  // Expected magic byte "DICM" at position idx
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0:    res = 8'h44;
      2'd1:    res = 8'h49;
      2'd2:    res = 8'h43;
      default: res = 8'h4D;
    endcase
    return res;
  endfunction

  // VRs followed by two reserved bytes and a 32-bit length
  function automatic logic vr_is_long(input logic [15:0] vr);
    logic res;
    case (vr)
      16'h4F42, 16'h4F44, 16'h4F46, 16'h4F4C, 16'h4F57,
      16'h5351, 16'h5543, 16'h5552, 16'h5554, 16'h554E: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  // Class code of a phase
  function automatic logic [3:0] phase_class(input phase_t ph);
    logic [3:0] res;
    case (ph)
      PH_PREAMBLE: res = CLS_PREAMBLE;
      PH_MAGIC:    res = CLS_MAGIC;
      PH_GROUP:    res = CLS_GROUP;
      PH_ELEMENT:  res = CLS_ELEMENT;
      PH_VR:       res = CLS_VR;
      PH_RESERVED: res = CLS_RESERVED;
      PH_LENGTH:   res = CLS_LENGTH;
      PH_VALUE:    res = CLS_VALUE;
      default:     res = CLS_IGNORED;
    endcase
    return res;
  endfunction

endpackage

[rtl/dicom_element_header_parser.sv]
`timescale 1ns / 1ps
// Latency: a word accepted at one edge shows its result on out_tvalid the next cycle.
// Throughput: one byte per cycle; the per-byte phase update is combinational.
// A waiting result holds off the input; the next byte enters in the cycle it is taken.
// Reset (rst_n low, synchronous) clears the parser to the preamble phase (the magic phase if PREAMBLE_BYTES[7:0] is 0).
// in_tuser[0] (file start) restarts the parser on that byte.
// ----------------------------------------------------------------------------
// dicom_element_header_parser
// Classifies each byte of an explicit VR little-endian DICOM stream and
// reports the header fields of the element being parsed.
// ----------------------------------------------------------------------------
module dicom_element_header_parser #(
  parameter int unsigned PREAMBLE_BYTES = dehp_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic [0:0]                        in_tuser,   // [0] file_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] group_number, [31:16] element_number, [47:32] vr_chars,
  // [48] long_length_form, [80:49] value_length, [81] header_done,
  // [82] is_pixel_data, [83] magic_error, [87:84] zero
  output logic [dehp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [3:0]                        out_tuser,  // [3:0] byte_class
  output logic                              out_tlast   // value_last
);

  localparam logic [7:0] PRE_CNT = PREAMBLE_BYTES[7:0];
  localparam dehp_pkg::phase_t START_PHASE =
    (PRE_CNT == 8'd0) ? dehp_pkg::PH_MAGIC : dehp_pkg::PH_PREAMBLE;

  // Parser state
  dehp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [15:0]      group_r, group_nxt;
  logic [15:0]      elem_r, elem_nxt;
  logic [15:0]      vr_r, vr_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic             magic_bad_r, magic_bad_nxt;

  // Result register
  logic             out_valid_r;
  logic [3:0]       cls_r, cls_nxt;
  logic             hdr_done_r, hdr_done_nxt;
  logic             val_last_r, val_last_nxt;

  logic             in_acc;
  logic             restart;
  dehp_pkg::phase_t cur_phase;
  logic [7:0]       cur_pos;
  logic [15:0]      cur_group, cur_elem, cur_vr;
  logic [31:0]      cur_len, cur_remain;
  logic             cur_bad;
  logic [7:0]       pos_inc;
  logic [7:0]       byte_in;
  logic             lng;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign restart   = in_tuser[0];
  assign byte_in   = in_tdata;

  // State as seen by this byte, after an optional restart
  always_comb begin
    if (restart) begin
      cur_phase  = START_PHASE;
      cur_pos    = '0;
      cur_group  = '0;
      cur_elem   = '0;
      cur_vr     = '0;
      cur_len    = '0;
      cur_remain = '0;
      cur_bad    = 1'b0;
    end else begin
      cur_phase  = phase_r;
      cur_pos    = pos_r;
      cur_group  = group_r;
      cur_elem   = elem_r;
      cur_vr     = vr_r;
      cur_len    = len_r;
      cur_remain = remain_r;
      cur_bad    = magic_bad_r;
    end
  end

  assign pos_inc = cur_pos + 8'd1;
  assign lng     = dehp_pkg::vr_is_long(cur_vr);

  // Per-byte phase update
  always_comb begin
    phase_nxt     = cur_phase;
    pos_nxt       = cur_pos;
    group_nxt     = cur_group;
    elem_nxt      = cur_elem;
    vr_nxt        = cur_vr;
    len_nxt       = cur_len;
    remain_nxt    = cur_remain;
    magic_bad_nxt = cur_bad;
    hdr_done_nxt  = 1'b0;
    val_last_nxt  = 1'b0;
    cls_nxt       = dehp_pkg::phase_class(cur_phase);

    case (cur_phase)
      dehp_pkg::PH_PREAMBLE: begin
        pos_nxt = pos_inc;
        if (pos_inc >= PRE_CNT) begin
          phase_nxt = dehp_pkg::PH_MAGIC;
          pos_nxt   = '0;
        end
      end
      dehp_pkg::PH_MAGIC: begin
        if (byte_in != dehp_pkg::magic_byte(cur_pos[1:0])) magic_bad_nxt = 1'b1;
        pos_nxt = pos_inc;
        if (pos_inc >= 8'd4) begin
          pos_nxt   = '0;
          phase_nxt = magic_bad_nxt ? dehp_pkg::PH_IGNORED : dehp_pkg::PH_GROUP;
        end
      end
      dehp_pkg::PH_GROUP: begin
        if (cur_pos == 8'd0) begin
          group_nxt = {8'h00, byte_in};
          elem_nxt  = '0;
          vr_nxt    = '0;
          len_nxt   = '0;
          pos_nxt   = 8'd1;
        end else begin
          group_nxt = {byte_in, cur_group[7:0]};
          pos_nxt   = '0;
          phase_nxt = dehp_pkg::PH_ELEMENT;
        end
      end
      dehp_pkg::PH_ELEMENT: begin
        if (cur_pos == 8'd0) begin
          elem_nxt = {8'h00, byte_in};
          pos_nxt  = 8'd1;
        end else begin
          elem_nxt  = {byte_in, cur_elem[7:0]};
          pos_nxt   = '0;
          phase_nxt = dehp_pkg::PH_VR;
        end
      end
      dehp_pkg::PH_VR: begin
        if (cur_pos == 8'd0) begin
          vr_nxt  = {byte_in, 8'h00};
          pos_nxt = 8'd1;
        end else begin
          vr_nxt    = {cur_vr[15:8], byte_in};
          pos_nxt   = '0;
          phase_nxt = dehp_pkg::vr_is_long(vr_nxt) ? dehp_pkg::PH_RESERVED
                                                   : dehp_pkg::PH_LENGTH;
        end
      end
      dehp_pkg::PH_RESERVED: begin
        if (cur_pos == 8'd0) begin
          pos_nxt = 8'd1;
        end else begin
          pos_nxt   = '0;
          phase_nxt = dehp_pkg::PH_LENGTH;
        end
      end
      dehp_pkg::PH_LENGTH: begin
        // little-endian byte lane select
        len_nxt = cur_len | (32'(byte_in) << {cur_pos[1:0], 3'b000});
        pos_nxt = pos_inc;
        if (pos_inc >= (lng ? 8'd4 : 8'd2)) begin
          pos_nxt      = '0;
          hdr_done_nxt = 1'b1;
          remain_nxt   = len_nxt;
          if (len_nxt == 32'd0) begin
            val_last_nxt = 1'b1;
            phase_nxt    = dehp_pkg::PH_GROUP;
          end else begin
            phase_nxt = dehp_pkg::PH_VALUE;
          end
        end
      end
      dehp_pkg::PH_VALUE: begin
        remain_nxt = cur_remain - 32'd1;
        if (remain_nxt == 32'd0) begin
          val_last_nxt = 1'b1;
          phase_nxt    = dehp_pkg::PH_GROUP;
        end
      end
      default: begin
        cls_nxt   = dehp_pkg::CLS_IGNORED;
        phase_nxt = dehp_pkg::PH_IGNORED;
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= START_PHASE;
      pos_r       <= '0;
      group_r     <= '0;
      elem_r      <= '0;
      vr_r        <= '0;
      len_r       <= '0;
      remain_r    <= '0;
      magic_bad_r <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      group_r     <= group_nxt;
      elem_r      <= elem_nxt;
      vr_r        <= vr_nxt;
      len_r       <= len_nxt;
      remain_r    <= remain_nxt;
      magic_bad_r <= magic_bad_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cls_r      <= cls_nxt;
      hdr_done_r <= hdr_done_nxt;
      val_last_r <= val_last_nxt;
    end
  end

  // Header fields come straight from the state registers, which move with the result
  assign out_tvalid = out_valid_r;
  assign out_tuser  = cls_r;
  assign out_tlast  = val_last_r;
  assign out_tdata  = {4'b0000,
                       magic_bad_r,
                       (group_r == dehp_pkg::PIXEL_GROUP) &&
                         (elem_r == dehp_pkg::PIXEL_ELEMENT),
                       hdr_done_r,
                       len_r,
                       dehp_pkg::vr_is_long(vr_r),
                       vr_r,
                       elem_r,
                       group_r};

  // Assertions
  a_hdr_done_on_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hdr_done_r |-> cls_r == dehp_pkg::CLS_LENGTH)
    else $error("header_done outside a length byte");

  a_zero_len_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && val_last_r && cls_r == dehp_pkg::CLS_LENGTH |-> len_r == 32'd0)
    else $error("element ended on length byte with nonzero length");

  a_magic_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    magic_bad_r && !(in_acc && restart) |=> magic_bad_r)
    else $error("magic error cleared without a restart");

  a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && val_last_r |->
      (cls_r == dehp_pkg::CLS_LENGTH || cls_r == dehp_pkg::CLS_VALUE))
    else $error("value_last on a byte that is neither length nor value");

endmodule

[sim/dehp_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehp_stream_checker
// Watches both streams of the DICOM element header parser. Every accepted
// input word is run through a local parser model and the predicted report is
// queued; every accepted result word is compared field by field with the
// oldest queued report.
// ----------------------------------------------------------------------------
module dehp_stream_checker #(
  parameter int unsigned PREAMBLE_BYTES = dehp_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic [0:0]                      in_tuser,   // [0] file_start
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] group, [31:16] element, [47:32] vr, [48] long form,
  // [80:49] length, [81] header done, [82] pixel data, [83] magic error
  input  logic [dehp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [3:0]                      out_tuser,  // [3:0] byte_class
  input  logic                            out_tlast,  // value_last
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam logic [31:0] MAGIC_WORD = "DICM";

  typedef struct packed {
    logic [3:0]  byte_class;
    logic [15:0] group_number;
    logic [15:0] element_number;
    logic [15:0] vr_chars;
    logic        long_form;
    logic [31:0] value_length;
    logic        header_done;
    logic        value_last;
    logic        pixel_data;
    logic        magic_error;
    logic [3:0]  pad;
  } byte_report_t;

  // Parser model state
  logic [3:0]  ps_phase;
  logic [7:0]  ps_pos;
  logic [15:0] ps_group;
  logic [15:0] ps_element;
  logic [15:0] ps_vr;
  logic [31:0] ps_length;
  logic [31:0] ps_remaining;
  logic        ps_magic_bad;

  byte_report_t pending_reports[$];
  int           n_fail;
  int           n_checked;

  // VRs with two reserved bytes and a 32-bit length
  function automatic logic long_form_vr(input logic [15:0] vr);
    case (vr)
      "OB", "OD", "OF", "OL", "OW", "SQ", "UC", "UR", "UT", "UN": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void restart_parser();
    ps_phase     = (PREAMBLE_BYTES[7:0] == 8'd0) ? dehp_pkg::CLS_MAGIC
                                                 : dehp_pkg::CLS_PREAMBLE;
    ps_pos       = '0;
    ps_group     = '0;
    ps_element   = '0;
    ps_vr        = '0;
    ps_length    = '0;
    ps_remaining = '0;
    ps_magic_bad = 1'b0;
  endfunction

  // Advance the model by one byte and build the report it should produce
  function automatic byte_report_t parse_byte(input logic [7:0] b, input logic start);
    byte_report_t r;
    logic         lng;
    int           shift;
    r = '0;
    if (start) restart_parser();
    r.byte_class = ps_phase;
    lng = long_form_vr(ps_vr);
    case (ps_phase)
      dehp_pkg::CLS_PREAMBLE: begin
        ps_pos = ps_pos + 8'd1;
        if (ps_pos >= PREAMBLE_BYTES[7:0]) begin
          ps_phase = dehp_pkg::CLS_MAGIC;
          ps_pos   = '0;
        end
      end
      dehp_pkg::CLS_MAGIC: begin
        shift = 8 * (3 - int'(ps_pos[1:0]));
        if (b != 8'(MAGIC_WORD >> shift)) ps_magic_bad = 1'b1;
        ps_pos = ps_pos + 8'd1;
        if (ps_pos >= 8'd4) begin
          ps_pos   = '0;
          ps_phase = ps_magic_bad ? dehp_pkg::CLS_IGNORED : dehp_pkg::CLS_GROUP;
        end
      end
      dehp_pkg::CLS_GROUP: begin
        if (ps_pos == 8'd0) begin
          // first group byte opens a new element
          ps_group   = {8'h00, b};
          ps_element = '0;
          ps_vr      = '0;
          ps_length  = '0;
          ps_pos     = 8'd1;
        end else begin
          ps_group[15:8] = b;
          ps_pos         = '0;
          ps_phase       = dehp_pkg::CLS_ELEMENT;
        end
      end
      dehp_pkg::CLS_ELEMENT: begin
        if (ps_pos == 8'd0) begin
          ps_element = {8'h00, b};
          ps_pos     = 8'd1;
        end else begin
          ps_element[15:8] = b;
          ps_pos           = '0;
          ps_phase         = dehp_pkg::CLS_VR;
        end
      end
      dehp_pkg::CLS_VR: begin
        if (ps_pos == 8'd0) begin
          ps_vr  = {b, 8'h00};
          ps_pos = 8'd1;
        end else begin
          ps_vr[7:0] = b;
          ps_pos     = '0;
          ps_phase   = long_form_vr(ps_vr) ? dehp_pkg::CLS_RESERVED
                                           : dehp_pkg::CLS_LENGTH;
        end
      end
      dehp_pkg::CLS_RESERVED: begin
        if (ps_pos == 8'd0) begin
          ps_pos = 8'd1;
        end else begin
          ps_pos   = '0;
          ps_phase = dehp_pkg::CLS_LENGTH;
        end
      end
      dehp_pkg::CLS_LENGTH: begin
        ps_length = ps_length | (32'(b) << (8 * int'(ps_pos[1:0])));
        ps_pos    = ps_pos + 8'd1;
        if (ps_pos >= (lng ? 8'd4 : 8'd2)) begin
          ps_pos         = '0;
          r.header_done  = 1'b1;
          ps_remaining   = ps_length;
          if (ps_remaining == 32'd0) begin
            r.value_last = 1'b1;
            ps_phase     = dehp_pkg::CLS_GROUP;
          end else begin
            ps_phase = dehp_pkg::CLS_VALUE;
          end
        end
      end
      dehp_pkg::CLS_VALUE: begin
        ps_remaining = ps_remaining - 32'd1;
        if (ps_remaining == 32'd0) begin
          r.value_last = 1'b1;
          ps_phase     = dehp_pkg::CLS_GROUP;
        end
      end
      default: begin
        r.byte_class = dehp_pkg::CLS_IGNORED;
        ps_phase     = dehp_pkg::CLS_IGNORED;
      end
    endcase
    r.group_number   = ps_group;
    r.element_number = ps_element;
    r.vr_chars       = ps_vr;
    r.long_form      = long_form_vr(ps_vr);
    r.value_length   = ps_length;
    r.pixel_data     = (ps_group == dehp_pkg::PIXEL_GROUP) &&
                       (ps_element == dehp_pkg::PIXEL_ELEMENT);
    r.magic_error    = ps_magic_bad;
    return r;
  endfunction

  function automatic string report_text(input byte_report_t r);
    return $sformatf("cls %0d grp %h elm %h vr %h lf %b len %h hd %b vl %b px %b me %b pad %h",
                     r.byte_class, r.group_number, r.element_number, r.vr_chars,
                     r.long_form, r.value_length, r.header_done, r.value_last,
                     r.pixel_data, r.magic_error, r.pad);
  endfunction

  // Compare result words first, then queue the prediction for a new input
  always @(posedge clk) begin
    byte_report_t want;
    byte_report_t got;
    string        bad;
    if (!rst_n) begin
      restart_parser();
      pending_reports.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.byte_class     = out_tuser;
        got.group_number   = out_tdata[15:0];
        got.element_number = out_tdata[31:16];
        got.vr_chars       = out_tdata[47:32];
        got.long_form      = out_tdata[48];
        got.value_length   = out_tdata[80:49];
        got.header_done    = out_tdata[81];
        got.value_last     = out_tlast;
        got.pixel_data     = out_tdata[82];
        got.magic_error    = out_tdata[83];
        got.pad            = out_tdata[87:84];
        if (pending_reports.size() == 0) begin
          n_fail++;
          if (n_fail <= SHOWN_MISMATCHES)
            $display("[%0t] result word with nothing expected: %s", $time, report_text(got));
        end else begin
          want = pending_reports.pop_front();
          bad  = "";
          if (got.byte_class !== want.byte_class)         bad = {bad, " class"};
          if (got.group_number !== want.group_number)     bad = {bad, " group"};
          if (got.element_number !== want.element_number) bad = {bad, " element"};
          if (got.vr_chars !== want.vr_chars)             bad = {bad, " vr"};
          if (got.long_form !== want.long_form)           bad = {bad, " long_form"};
          if (got.value_length !== want.value_length)     bad = {bad, " length"};
          if (got.header_done !== want.header_done)       bad = {bad, " header_done"};
          if (got.value_last !== want.value_last)         bad = {bad, " value_last"};
          if (got.pixel_data !== want.pixel_data)         bad = {bad, " pixel_data"};
          if (got.magic_error !== want.magic_error)       bad = {bad, " magic_error"};
          if (got.pad !== want.pad)                       bad = {bad, " pad"};
          if (bad != "") begin
            n_fail++;
            if (n_fail <= SHOWN_MISMATCHES) begin
              $display("[%0t] word %0d mismatch in%s", $time, n_checked, bad);
              $display("  expected %s", report_text(want));
              $display("  actual   %s", report_text(got));
            end
          end
        end
        n_checked++;
      end
      if (in_tvalid && in_tready)
        pending_reports.push_back(parse_byte(in_tdata, in_tuser[0]));
    end
    fail_count <= n_fail;
    pending    <= pending_reports.size();
    checked    <= n_checked;
  end

endmodule

[sim/tb_dicom_element_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dicom_element_header_parser
// Feeds DICOM byte streams into the element header parser: a directed file
// with extreme bytes, every long-form VR, zero and undefined lengths, the
// pixel data tag and broken magic, then random files built from well-formed
// elements mixed with noise, bad magic and headers cut by a restart. Both
// stream sides idle at random; a separate checker predicts every word.
// ----------------------------------------------------------------------------
module tb_dicom_element_header_parser;

  localparam int unsigned PREAMBLE        = dehp_pkg::PREAMBLE_BYTES_DEF;
  localparam int          RANDOM_BYTES    = 540;
  localparam int          WATCHDOG_CYCLES = 2000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam logic [31:0] MAGIC_WORD      = "DICM";
  localparam int          NO_BAD_BYTE     = -1;

  localparam logic [15:0] LONG_VRS [10] = '{"OB", "OD", "OF", "OL", "OW",
                                            "SQ", "UC", "UR", "UT", "UN"};
  localparam logic [15:0] SHORT_VRS [8] = '{"UI", "US", "LO", "DA",
                                            "CS", "PN", "SH", "UL"};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] data_byte
  logic [0:0]            in_tuser   = '0;   // [0] file_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] group, [31:16] element, [47:32] vr, [48] long form,
  // [80:49] length, [81] header done, [82] pixel data, [83] magic error
  logic [dehp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [3:0]            out_tuser;         // [3:0] byte_class
  logic                  out_tlast;         // value_last

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping
  int burst_left   = 0;
  int bytes_sent   = 0;
  int files_sent   = 0;
  int bad_magic    = 0;
  int elements     = 0;
  int pixel_tags   = 0;
  int quiet_cycles = 0;

  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_run_left;

  dicom_element_header_parser #(
    .PREAMBLE_BYTES(PREAMBLE)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dehp_stream_checker #(
    .PREAMBLE_BYTES(PREAMBLE)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Result side backpressure, switching between a few stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_mode_left <= 0;
      rx_run_left  <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 160);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (rx_run_left == 0) begin
            out_tready  <= !out_tready;
            rx_run_left <= $urandom_range(1, 12);
          end else begin
            rx_run_left <= rx_run_left - 1;
          end
        end
      endcase
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One input word, with bursts and random gaps in front of it
  task automatic put_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 48);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Hold off the sender until every predicted word has been seen
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Preamble and magic; bad_pos picks a magic byte to corrupt
  task automatic put_file_head(input logic start, input int bad_pos, input logic extremes);
    logic [7:0] b;
    for (int i = 0; i < PREAMBLE; i++) begin
      b = extremes ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom);
      put_byte(b, start && (i == 0));
    end
    for (int i = 0; i < 4; i++) begin
      b = 8'(MAGIC_WORD >> (8 * (3 - i)));
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      put_byte(b, 1'b0);
    end
    files_sent++;
    if (bad_pos != NO_BAD_BYTE) bad_magic++;
  endtask

  // Element header followed by n_vals value bytes
  task automatic put_element(input logic [15:0] grp, input logic [15:0] elm,
                             input logic [15:0] vr, input logic [31:0] len,
                             input int n_vals);
    put_byte(grp[7:0], 1'b0);
    put_byte(grp[15:8], 1'b0);
    put_byte(elm[7:0], 1'b0);
    put_byte(elm[15:8], 1'b0);
    put_byte(vr[15:8], 1'b0);
    put_byte(vr[7:0], 1'b0);
    if (dehp_pkg::vr_is_long(vr)) begin
      put_byte(8'($urandom), 1'b0);
      put_byte(8'($urandom), 1'b0);
      for (int i = 0; i < 4; i++) put_byte(len[8*i +: 8], 1'b0);
    end else begin
      put_byte(len[7:0], 1'b0);
      put_byte(len[15:8], 1'b0);
    end
    repeat (n_vals) put_byte(8'($urandom), 1'b0);
    elements++;
    if (grp == dehp_pkg::PIXEL_GROUP && elm == dehp_pkg::PIXEL_ELEMENT) pixel_tags++;
  endtask

  // One random file: mostly well-formed elements, some noise and bad magic
  task automatic random_file();
    int          kind;
    int          bad_pos;
    int          n_elems;
    int          n_vals;
    logic [15:0] grp;
    logic [15:0] elm;
    logic [15:0] vr;
    logic [31:0] len;
    kind    = $urandom_range(0, 9);
    bad_pos = (kind == 0) ? int'($urandom_range(0, 3)) : NO_BAD_BYTE;
    put_file_head(1'b1, bad_pos, 1'b0);
    if (kind <= 1) begin
      // everything after a bad magic is ignored; after a good one it is junk
      repeat ($urandom_range(8, 60)) put_byte(8'($urandom), 1'b0);
    end else begin
      n_elems = $urandom_range(4, 24);
      for (int e = 0; e < n_elems; e++) begin
        case ($urandom_range(0, 5))
          0: begin
            grp = dehp_pkg::PIXEL_GROUP;
            elm = dehp_pkg::PIXEL_ELEMENT;
          end
          1: begin
            grp = dehp_pkg::PIXEL_GROUP;
            elm = 16'($urandom);
          end
          2: begin
            grp = 16'($urandom);
            elm = dehp_pkg::PIXEL_ELEMENT;
          end
          default: begin
            grp = 16'($urandom);
            elm = 16'($urandom);
          end
        endcase
        case ($urandom_range(0, 4))
          0, 1:    vr = LONG_VRS[$urandom_range(0, 9)];
          2, 3:    vr = SHORT_VRS[$urandom_range(0, 7)];
          default: vr = 16'($urandom);
        endcase
        if (e == n_elems - 1 && $urandom_range(0, 2) == 0) begin
          // large length, value cut short by the next file
          len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
          if (!dehp_pkg::vr_is_long(vr)) len[31:16] = '0;
          n_vals = $urandom_range(0, 6);
        end else begin
          len    = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
          n_vals = int'(len);
        end
        put_element(grp, elm, vr, len, n_vals);
      end
      // a header left unfinished by the next restart
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 7)) put_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int random_start;
    int random_files;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a file straight out of reset, no start flag, extreme preamble
    put_file_head(1'b0, NO_BAD_BYTE, 1'b1);
    put_element(16'h0002, 16'h0010, "UI", 32'd3, 3);
    put_element(16'hFFFF, 16'hFFFF, "OB", 32'd0, 0);     // long form, zero length
    put_element(16'h0000, 16'h0000, "US", 32'd0, 0);     // short form, zero length
    put_element(dehp_pkg::PIXEL_GROUP, dehp_pkg::PIXEL_ELEMENT, "OW", 32'd2, 2);
    for (int i = 0; i < 10; i++)
      put_element(16'h0008, 16'(i), LONG_VRS[i], 32'd1, 1);
    put_element(16'h0010, 16'h0020, "OX", 32'd2, 2);    // looks long, is not
    // undefined length is just a huge count; the next file cuts it off
    put_element(dehp_pkg::PIXEL_GROUP, dehp_pkg::PIXEL_ELEMENT, "UN", 32'hFFFF_FFFF, 4);
    // bad magic on the first byte, then ignored extremes
    put_file_head(1'b1, 0, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    // bad magic on the last byte
    put_file_head(1'b1, 3, 1'b0);
    put_byte(8'h44, 1'b0);
    // good file restarted halfway through a group
    put_file_head(1'b1, NO_BAD_BYTE, 1'b0);
    put_byte(8'hE0, 1'b0);
    drain_results();

    // Random files
    random_start = bytes_sent;
    random_files = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      random_file();
      random_files++;
      if (random_files == 2) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d files (%0d with bad magic), %0d elements, %0d pixel tags",
             bytes_sent, files_sent, bad_magic, elements, pixel_tags);
    $display("Checked %0d result words, %0d failures", checked, fail_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
